FILE: rtl/core/lrl_pkg.sv
// Package for the loss-driven rate ladder: widths, register indexes, reset values and rung codes.
// Depends on nothing; every other file of the block uses it by scoped names.
package lrl_pkg;

	// Counter width and saturation value.
	localparam int COUNT_BITS = 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Field widths.
	localparam int LOSS_W  = 10;
	localparam int CNT_CFG_W = 8;
	localparam int FEC_W   = 7;
	localparam int RUNG_W  = 2;
	localparam int TENTHS_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	// Counters and their limits are compared at the wider of the two widths.
	localparam int CMP_W = (COUNT_BITS > CNT_CFG_W) ? COUNT_BITS : CNT_CFG_W;

	// Constant outputs per rung and the FEC ceiling.
	localparam logic [TENTHS_W-1:0] TENTHS_GOOD       = 4'd10;
	localparam logic [TENTHS_W-1:0] TENTHS_RECOVERING = 4'd7;
	localparam logic [TENTHS_W-1:0] TENTHS_DEGRADED   = 4'd4;
	localparam logic [FEC_W-1:0] FEC_CAP = 7'd100;

	// Register reset values.
	localparam logic [LOSS_W-1:0]    RST_LOSS_THRESHOLD = 10'd30;
	localparam logic [CNT_CFG_W-1:0] RST_DEGRADE_AFTER  = 8'd2;
	localparam logic [CNT_CFG_W-1:0] RST_CLIMB_AFTER    = 8'd15;
	localparam logic [FEC_W-1:0]     RST_BASE_FEC       = 7'd25;
	localparam logic [FEC_W-1:0]     RST_DEGRADED_FEC   = 7'd100;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOSS_THRESHOLD = 3'd0,
		CFG_DEGRADE_AFTER  = 3'd1,
		CFG_CLIMB_AFTER    = 3'd2,
		CFG_BASE_FEC       = 3'd3,
		CFG_DEGRADED_FEC   = 3'd4
	} cfg_idx_t;

	// Ladder rungs.
	typedef enum logic [RUNG_W-1:0] {
		RUNG_GOOD       = 2'd0,
		RUNG_RECOVERING = 2'd1,
		RUNG_DEGRADED   = 2'd2
	} rung_t;

	// Configuration register set as seen by the datapath.
	typedef struct packed {
		logic [LOSS_W-1:0]    loss_threshold;
		logic [CNT_CFG_W-1:0] degrade_after;
		logic [CNT_CFG_W-1:0] climb_after;
		logic [FEC_W-1:0]     base_fec_percent;
		logic [FEC_W-1:0]     degraded_fec_percent;
	} cfg_t;

endpackage

FILE: rtl/core/lrl_if.sv
// Valid/ready channel interfaces for the rate ladder's input ticks and result items.
// Depends on lrl_pkg for the field widths.
interface lrl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        peers_present;
	logic                        loss_valid;
	logic [lrl_pkg::LOSS_W-1:0]  loss_level;

	modport source (output valid, peers_present, loss_valid, loss_level, input ready);
	modport sink   (input valid, peers_present, loss_valid, loss_level, output ready);
endinterface

interface lrl_out_if;
	logic                          valid;
	logic                          ready;
	logic [lrl_pkg::RUNG_W-1:0]    rung;
	logic                          rung_changed;
	logic [lrl_pkg::TENTHS_W-1:0]  bitrate_tenths;
	logic [lrl_pkg::FEC_W-1:0]     fec_percent;

	modport source (output valid, rung, rung_changed, bitrate_tenths, fec_percent, input ready);
	modport sink   (input valid, rung, rung_changed, bitrate_tenths, fec_percent, output ready);
endinterface

FILE: rtl/core/lrl_cfg_regs.sv
// Configuration register file of the rate ladder: five write-only registers.
// Depends on lrl_pkg for indexes, widths and reset values.
module lrl_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [lrl_pkg::CFG_IDX_W-1:0]   index,
	input  logic [lrl_pkg::CFG_DATA_W-1:0]  data,
	output lrl_pkg::cfg_t                   cfg
);

	lrl_pkg::cfg_t cfg_q;

	// Each write lands in the register its index selects; other indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loss_threshold       <= lrl_pkg::RST_LOSS_THRESHOLD;
			cfg_q.degrade_after        <= lrl_pkg::RST_DEGRADE_AFTER;
			cfg_q.climb_after          <= lrl_pkg::RST_CLIMB_AFTER;
			cfg_q.base_fec_percent     <= lrl_pkg::RST_BASE_FEC;
			cfg_q.degraded_fec_percent <= lrl_pkg::RST_DEGRADED_FEC;
		end else if (we) begin
			unique case (lrl_pkg::cfg_idx_t'(index))
				lrl_pkg::CFG_LOSS_THRESHOLD: begin
					cfg_q.loss_threshold <= data[lrl_pkg::LOSS_W-1:0];
				end
				lrl_pkg::CFG_DEGRADE_AFTER: begin
					cfg_q.degrade_after <= data[lrl_pkg::CNT_CFG_W-1:0];
				end
				lrl_pkg::CFG_CLIMB_AFTER: begin
					cfg_q.climb_after <= data[lrl_pkg::CNT_CFG_W-1:0];
				end
				lrl_pkg::CFG_BASE_FEC: begin
					cfg_q.base_fec_percent <= data[lrl_pkg::FEC_W-1:0];
				end
				lrl_pkg::CFG_DEGRADED_FEC: begin
					cfg_q.degraded_fec_percent <= data[lrl_pkg::FEC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/loss_driven_rate_ladder_top.sv
// Top level of the loss-driven rate ladder: input register, ladder update, result register.
// Depends on lrl_pkg, lrl_if (channel interfaces) and lrl_cfg_regs.

// The block takes one adaptation tick per clock cycle unless it stalls, and
// returns exactly one result item per tick; a tick passes through the input
// register and then the result register. The ladder state (rung, bad count,
// clean count) is updated in the same cycle a tick leaves the input register,
// so the next tick sees it at once. While a finished result waits to be taken,
// an empty input register still takes one more tick; both registers stall
// together only when the result is held and a tick is waiting.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while no tick is in flight; the block itself does not enforce this.
// Indexes beyond the five registers are ignored.
module loss_driven_rate_ladder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	lrl_in_if.sink                          in_ch,
	lrl_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [lrl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lrl_pkg::cfg_t cfg;

	// Input register.
	logic                        s1_valid_q;
	logic                        peers_s1;
	logic                        lvalid_s1;
	logic [lrl_pkg::LOSS_W-1:0]  loss_s1;

	// Ladder state.
	lrl_pkg::rung_t                 rung_q;
	logic [lrl_pkg::COUNT_BITS-1:0] bad_q;
	logic [lrl_pkg::COUNT_BITS-1:0] clean_q;

	// Result register.
	logic                          out_valid_q;
	lrl_pkg::rung_t                out_rung_q;
	logic                          out_changed_q;
	logic [lrl_pkg::TENTHS_W-1:0]  out_tenths_q;
	logic [lrl_pkg::FEC_W-1:0]     out_fec_q;

	// Next-state and result values.
	lrl_pkg::rung_t                 rung_n;
	logic [lrl_pkg::COUNT_BITS-1:0] bad_n;
	logic [lrl_pkg::COUNT_BITS-1:0] clean_n;
	logic [lrl_pkg::TENTHS_W-1:0]   tenths_n;
	logic [lrl_pkg::FEC_W-1:0]      fec_n;
	logic [lrl_pkg::FEC_W-1:0]      base_cap;
	logic [lrl_pkg::FEC_W-1:0]      deg_cap;
	logic [lrl_pkg::FEC_W:0]        base_dbl;
	logic [lrl_pkg::FEC_W-1:0]      rec_fec;

	logic advance;
	logic accept;

	lrl_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Handshake: the tick in the input register moves on when the result slot frees.
	assign advance      = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !s1_valid_q || advance;
	assign accept       = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			peers_s1  <= in_ch.peers_present;
			lvalid_s1 <= in_ch.loss_valid;
			loss_s1   <= in_ch.loss_level;
		end
	end

	// Counter update and rung transition for the tick in the input register.
	always_comb begin
		bad_n   = bad_q;
		clean_n = clean_q;
		rung_n  = rung_q;
		if (!peers_s1) begin
			bad_n   = '0;
			clean_n = '0;
			rung_n  = lrl_pkg::RUNG_GOOD;
		end else begin
			if (lvalid_s1) begin
				if (loss_s1 >= cfg.loss_threshold) begin
					bad_n   = (bad_q == lrl_pkg::COUNT_MAX) ? bad_q
					          : bad_q + lrl_pkg::COUNT_BITS'(1);
					clean_n = '0;
				end else begin
					bad_n   = '0;
					clean_n = (clean_q == lrl_pkg::COUNT_MAX) ? clean_q
					          : clean_q + lrl_pkg::COUNT_BITS'(1);
				end
			end
			// A drop to degraded wins over a climb.
			priority if (lrl_pkg::CMP_W'(bad_n) >= lrl_pkg::CMP_W'(cfg.degrade_after)
			             && rung_q != lrl_pkg::RUNG_DEGRADED) begin
				rung_n = lrl_pkg::RUNG_DEGRADED;
			end else if (lrl_pkg::CMP_W'(clean_n) >= lrl_pkg::CMP_W'(cfg.climb_after)
			             && rung_q != lrl_pkg::RUNG_GOOD) begin
				clean_n = '0;
				rung_n  = (rung_q == lrl_pkg::RUNG_DEGRADED) ? lrl_pkg::RUNG_RECOVERING
				          : lrl_pkg::RUNG_GOOD;
			end else begin
			end
		end
	end

	// Bitrate scale and FEC for the new rung; FEC values are capped at 100.
	assign base_cap = (cfg.base_fec_percent > lrl_pkg::FEC_CAP) ? lrl_pkg::FEC_CAP
	                  : cfg.base_fec_percent;
	assign deg_cap  = (cfg.degraded_fec_percent > lrl_pkg::FEC_CAP) ? lrl_pkg::FEC_CAP
	                  : cfg.degraded_fec_percent;
	assign base_dbl = {base_cap, 1'b0};
	assign rec_fec  = (base_dbl > {1'b0, lrl_pkg::FEC_CAP}) ? lrl_pkg::FEC_CAP
	                  : base_dbl[lrl_pkg::FEC_W-1:0];

	always_comb begin
		unique case (rung_n)
			lrl_pkg::RUNG_DEGRADED: begin
				tenths_n = lrl_pkg::TENTHS_DEGRADED;
				fec_n    = deg_cap;
			end
			lrl_pkg::RUNG_RECOVERING: begin
				tenths_n = lrl_pkg::TENTHS_RECOVERING;
				fec_n    = rec_fec;
			end
			default: begin
				tenths_n = lrl_pkg::TENTHS_GOOD;
				fec_n    = base_cap;
			end
		endcase
		// Zero base FEC turns FEC off on every rung.
		if (base_cap == '0) begin
			fec_n = '0;
		end
	end

	// Ladder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rung_q  <= lrl_pkg::RUNG_GOOD;
			bad_q   <= '0;
			clean_q <= '0;
		end else if (advance) begin
			rung_q  <= rung_n;
			bad_q   <= bad_n;
			clean_q <= clean_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rung_q    <= rung_n;
			out_changed_q <= (rung_n != rung_q);
			out_tenths_q  <= tenths_n;
			out_fec_q     <= fec_n;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.rung           = out_rung_q;
	assign out_ch.rung_changed   = out_changed_q;
	assign out_ch.bitrate_tenths = out_tenths_q;
	assign out_ch.fec_percent    = out_fec_q;

endmodule

FILE: rtl/core/lrl_checker.sv
// Port-level assertions for the rate ladder, bound to loss_driven_rate_ladder_top.
// Depends on lrl_pkg for widths and rung codes.
module lrl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lrl_pkg::RUNG_W-1:0]      rung,
	input logic                            rung_changed,
	input logic [lrl_pkg::TENTHS_W-1:0]    bitrate_tenths,
	input logic [lrl_pkg::FEC_W-1:0]       fec_percent
);

	// A stalled result item keeps its payload.
	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rung) && $stable(rung_changed)
			&& $stable(bitrate_tenths) && $stable(fec_percent);
	endproperty
	a_hold: assert property (p_hold) else $error("result item changed while stalled");

	// The bitrate scale always matches the reported rung.
	property p_tenths;
		@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(rung == lrl_pkg::RUNG_GOOD && bitrate_tenths == lrl_pkg::TENTHS_GOOD)
			|| (rung == lrl_pkg::RUNG_RECOVERING
			    && bitrate_tenths == lrl_pkg::TENTHS_RECOVERING)
			|| (rung == lrl_pkg::RUNG_DEGRADED
			    && bitrate_tenths == lrl_pkg::TENTHS_DEGRADED);
	endproperty
	a_tenths: assert property (p_tenths) else $error("bitrate scale does not match rung");

	// FEC never exceeds 100 percent.
	property p_fec_cap;
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> fec_percent <= lrl_pkg::FEC_CAP;
	endproperty
	a_fec_cap: assert property (p_fec_cap) else $error("FEC percent above cap");

	// Consecutive items with an unchanged rung cannot report a change flag
	// unless the rung differs from the previous item.
	property p_change;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && rung_changed |->
			rung != $past(rung) || !$past(out_valid) || !$past(out_ready);
	endproperty
	a_change: assert property (p_change) else $error("change flag without a rung change");

endmodule

bind loss_driven_rate_ladder_top lrl_checker u_lrl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.rung           (out_ch.rung),
	.rung_changed   (out_ch.rung_changed),
	.bitrate_tenths (out_ch.bitrate_tenths),
	.fec_percent    (out_ch.fec_percent)
);
